[rtl/core/sha1_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 engine package
// Shared constants and the word item type passed between the front end,
// the word queue and the compression back end.
// ---------------------------------------------------------------------------
package sha1_pkg;

	localparam int WORD_FIFO_DEPTH = 8;

	localparam int BLOCK_WORDS = 16;
	localparam int ROUNDS      = 80;
	localparam int PHASE1_END  = 20;
	localparam int PHASE2_END  = 40;
	localparam int PHASE3_END  = 60;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_PHASE1 = 32'h5A827999;
	localparam logic [31:0] K_PHASE2 = 32'h6ED9EBA1;
	localparam logic [31:0] K_PHASE3 = 32'h8F1BBCDC;
	localparam logic [31:0] K_PHASE4 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	// One 32-bit message word; final_blk marks the last word of a message.
	typedef struct packed {
		logic        final_blk;
		logic [31:0] word;
	} word_item_t;

endpackage
`default_nettype wire

[rtl/core/sha1_hash_engine.sv]
// From the end-of-message item to the first digest word, the engine pushes the padding
// words, takes the loads still owed, runs 80 rounds and one update per final block; a
// final block also waits until the previous digest has been drained.
// Bytes enter at one per cycle while full is low; each 64-byte block occupies the
// compression unit for 16 loads, 80 rounds and one update. Digest words leave at one
// per cycle while pop is held. After reset the chaining values hold the SHA-1 initial
// values and both queues are empty.
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 hash engine
// Streaming SHA-1: byte front end, word queue and round-serial compression.
// ---------------------------------------------------------------------------
module sha1_hash_engine #(
	parameter int FIFO_DEPTH = sha1_pkg::WORD_FIFO_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire  [7:0]  data_byte,
	input  wire         has_byte,
	input  wire         end_of_message,
	input  wire         push,
	output logic        full,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        empty,
	input  wire         pop
);
	import sha1_pkg::*;

	logic       f_push;
	word_item_t f_item;
	logic       f_full;
	logic       b_pop;
	word_item_t b_item;
	logic       b_empty;

	sha1_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.push           (push),
		.full           (full),
		.q_push         (f_push),
		.q_item         (f_item),
		.q_full         (f_full)
	);

	sha1_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (f_push),
		.wr_item (f_item),
		.full    (f_full),
		.rd      (b_pop),
		.rd_item (b_item),
		.empty   (b_empty)
	);

	sha1_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_item      (b_item),
		.q_empty     (b_empty),
		.q_pop       (b_pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word),
		.empty       (empty),
		.pop         (pop)
	);

endmodule
`default_nettype wire

[rtl/core/sha1_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 front end
// Takes message bytes, packs them big-endian into words, counts the message
// length and generates the padding and length words at the end of a message.
// ---------------------------------------------------------------------------
module sha1_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire  [7:0]              data_byte,
	input  wire                     has_byte,
	input  wire                     end_of_message,
	input  wire                     push,
	output logic                    full,
	output logic                    q_push,
	output sha1_pkg::word_item_t    q_item,
	input  wire                     q_full
);
	import sha1_pkg::*;

	typedef enum logic [1:0] {
		ST_BYTES,
		ST_PAD_FIRST,
		ST_PAD_ZERO,
		ST_LEN_LO
	} state_t;

	state_t      state_q;
	logic [5:0]  byte_in_block_q;
	logic [60:0] byte_count_q;
	logic [31:0] acc_q;

	logic        accept;
	logic [1:0]  lane;
	logic [4:0]  lane_shift;
	logic [31:0] acc_kept;
	logic [31:0] merged;
	logic [31:0] pad_word;
	logic [31:0] len_hi;
	logic [31:0] len_lo;

	assign full       = (state_q != ST_BYTES) || q_full;
	assign accept     = push && !full;
	assign lane       = byte_in_block_q[1:0];
	assign lane_shift = {~lane, 3'b000};
	// The first byte of a word overwrites the whole word.
	assign acc_kept   = (lane == 2'd0) ? 32'd0 : acc_q;
	assign merged     = acc_kept | ({24'd0, data_byte} << lane_shift);
	assign pad_word   = acc_kept | ({24'd0, PAD_MARK} << lane_shift);
	assign len_hi     = byte_count_q[60:29];
	assign len_lo     = {byte_count_q[28:0], 3'b000};

	always_comb begin
		q_push = 1'b0;
		q_item = '{final_blk: 1'b0, word: merged};
		case (state_q)
			ST_BYTES: begin
				q_push = accept && has_byte && (lane == 2'd3);
			end
			ST_PAD_FIRST: begin
				q_push      = !q_full;
				q_item.word = pad_word;
			end
			ST_PAD_ZERO: begin
				q_push      = !q_full;
				q_item.word = (byte_in_block_q[5:2] == 4'd14) ? len_hi : 32'd0;
			end
			ST_LEN_LO: begin
				q_push           = !q_full;
				q_item.word      = len_lo;
				q_item.final_blk = 1'b1;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_BYTES;
			byte_in_block_q <= '0;
			byte_count_q    <= '0;
		end else begin
			case (state_q)
				ST_BYTES: begin
					if (accept) begin
						if (has_byte) begin
							byte_in_block_q <= byte_in_block_q + 6'd1;
							byte_count_q    <= byte_count_q + 61'd1;
						end
						if (end_of_message) begin
							state_q <= ST_PAD_FIRST;
						end
					end
				end
				ST_PAD_FIRST: begin
					if (!q_full) begin
						byte_in_block_q <= {byte_in_block_q[5:2] + 4'd1, 2'b00};
						state_q         <= ST_PAD_ZERO;
					end
				end
				ST_PAD_ZERO: begin
					if (!q_full) begin
						byte_in_block_q <= {byte_in_block_q[5:2] + 4'd1, 2'b00};
						if (byte_in_block_q[5:2] == 4'd14) begin
							state_q <= ST_LEN_LO;
						end
					end
				end
				ST_LEN_LO: begin
					if (!q_full) begin
						byte_in_block_q <= '0;
						byte_count_q    <= '0;
						state_q         <= ST_BYTES;
					end
				end
				default: begin
					state_q <= ST_BYTES;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_byte) begin
			acc_q <= merged;
		end
	end

endmodule
`default_nettype wire

[rtl/core/sha1_fifo.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 word queue
// Short first-in first-out queue of message words between the front end and
// the compression back end.
// ---------------------------------------------------------------------------
module sha1_fifo #(
	parameter int DEPTH = sha1_pkg::WORD_FIFO_DEPTH
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     wr,
	input  sha1_pkg::word_item_t    wr_item,
	output logic                    full,
	input  wire                     rd,
	output sha1_pkg::word_item_t    rd_item,
	output logic                    empty
);
	import sha1_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	word_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule
`default_nettype wire

[rtl/core/sha1_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 compression back end
// Loads sixteen words, runs the eighty rounds one per cycle, updates the
// chaining values and hands out the digest words of each finished message.
// ---------------------------------------------------------------------------
module sha1_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  sha1_pkg::word_item_t    q_item,
	input  wire                     q_empty,
	output logic                    q_pop,
	output logic [31:0]             digest_word,
	output logic [2:0]              word_index,
	output logic                    last_word,
	output logic                    empty,
	input  wire                     pop
);
	import sha1_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_FINISH
	} state_t;

	state_t      state_q;
	logic [6:0]  t_q;
	logic        final_q;
	logic [31:0] h_q   [5];
	logic [31:0] av_q  [5];
	logic [31:0] w_q   [BLOCK_WORDS];
	logic [31:0] dig_q [5];
	logic        dig_valid_q;
	logic [2:0]  idx_q;

	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] tmp;
	logic [31:0] w_mix;
	logic [31:0] w_new;
	logic [31:0] sum   [5];
	logic        load_last;
	logic        round_last;
	logic        fin_go;
	logic        out_take;

	assign q_pop      = (state_q == ST_LOAD) && !q_empty;
	assign load_last  = q_pop && (t_q == 7'(BLOCK_WORDS - 1));
	assign round_last = (state_q == ST_ROUND) && (t_q == 7'(ROUNDS - 1));
	// A final block waits here until the previous digest has been drained.
	assign fin_go     = (state_q == ST_FINISH) && !(final_q && dig_valid_q);
	assign out_take   = pop && dig_valid_q;

	assign empty       = !dig_valid_q;
	assign digest_word = dig_q[0];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd4);

	always_comb begin
		if (t_q < 7'(PHASE1_END)) begin
			f_val = (av_q[1] & av_q[2]) | (~av_q[1] & av_q[3]);
			k_val = K_PHASE1;
		end else if (t_q < 7'(PHASE2_END)) begin
			f_val = av_q[1] ^ av_q[2] ^ av_q[3];
			k_val = K_PHASE2;
		end else if (t_q < 7'(PHASE3_END)) begin
			f_val = (av_q[1] & av_q[2]) | (av_q[1] & av_q[3]) | (av_q[2] & av_q[3]);
			k_val = K_PHASE3;
		end else begin
			f_val = av_q[1] ^ av_q[2] ^ av_q[3];
			k_val = K_PHASE4;
		end
	end

	// The schedule is a shift line: w_q[0] is the word of the current round.
	assign tmp   = {av_q[0][26:0], av_q[0][31:27]} + f_val + av_q[4] + k_val + w_q[0];
	assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new = {w_mix[30:0], w_mix[31]};

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			sum[i] = h_q[i] + av_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			t_q         <= '0;
			final_q     <= 1'b0;
			h_q         <= H_INIT;
			dig_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (out_take) begin
				if (idx_q == 3'd4) begin
					dig_valid_q <= 1'b0;
					idx_q       <= '0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
			case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						if (load_last) begin
							final_q <= q_item.final_blk;
							t_q     <= '0;
							state_q <= ST_ROUND;
						end else begin
							t_q <= t_q + 7'd1;
						end
					end
				end
				ST_ROUND: begin
					if (round_last) begin
						state_q <= ST_FINISH;
					end else begin
						t_q <= t_q + 7'd1;
					end
				end
				ST_FINISH: begin
					if (fin_go) begin
						if (final_q) begin
							h_q         <= H_INIT;
							dig_valid_q <= 1'b1;
							idx_q       <= '0;
						end else begin
							h_q <= sum;
						end
						t_q     <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLOCK_WORDS-1] <= q_item.word;
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLOCK_WORDS-1] <= w_new;
		end

		if (load_last) begin
			av_q <= h_q;
		end else if (state_q == ST_ROUND) begin
			av_q[0] <= tmp;
			av_q[1] <= av_q[0];
			av_q[2] <= {av_q[1][1:0], av_q[1][31:2]};
			av_q[3] <= av_q[2];
			av_q[4] <= av_q[3];
		end

		if (fin_go && final_q) begin
			dig_q <= sum;
		end else if (out_take) begin
			for (int i = 0; i < 4; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
	end

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (t_q < 7'(ROUNDS)))
		else $error("round counter beyond the last round");

	a_load_to_round: assert property (@(posedge clk) disable iff (!arst_n)
		load_last |=> (state_q == ST_ROUND) && (t_q == '0))
		else $error("full block did not start the rounds");

	a_digest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && (idx_q != 3'd4)) |=> dig_valid_q)
		else $error("digest dropped before its last word");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !q_pop)
		else $error("word taken while the rounds are running");

endmodule
`default_nettype wire

[verif/sha1_hash_engine_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 hash engine testbench
// Streams messages byte by byte into the engine and predicts each digest with
// an independent SHA-1 calculation. Every digest word is checked in order
// against that prediction, and both sides of the engine stall at random.
// ---------------------------------------------------------------------------
module sha1_hash_engine_tb;

	localparam int STALL_LIMIT    = 3000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int TARGET_ITEMS   = 300;
	localparam int MIN_MESSAGES   = 12;
	localparam int DIGEST_WORDS   = 5;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;
	localparam logic [31:0] RK0 = 32'h5A827999;
	localparam logic [31:0] RK1 = 32'h6ED9EBA1;
	localparam logic [31:0] RK2 = 32'h8F1BBCDC;
	localparam logic [31:0] RK3 = 32'hCA62C1D6;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	// Running SHA-1 of the byte stream and the digest words still owed.
	class digest_tracker;
		bit [31:0]    chain [5];
		bit [31:0]    block [16];
		bit [60:0]    msg_bytes;
		bit [5:0]     fill;
		digest_word_t owed_words [$];
		int           errors;

		function void restart();
			chain[0] = IV0;
			chain[1] = IV1;
			chain[2] = IV2;
			chain[3] = IV3;
			chain[4] = IV4;
			msg_bytes = '0;
			fill = '0;
		endfunction

		function bit [31:0] rotl(bit [31:0] v, int s);
			return (v << s) | (v >> (32 - s));
		endfunction

		function void compress_block();
			bit [31:0] w [16];
			bit [31:0] a, b, c, d, e, f, k, wt, sum;
			int t;
			w = block;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (t = 0; t < 80; t++) begin
				if (t >= 16) begin
					wt = rotl(w[(t + 13) & 15] ^ w[(t + 8) & 15] ^ w[(t + 2) & 15]
						^ w[t & 15], 1);
					w[t & 15] = wt;
				end else begin
					wt = w[t];
				end
				if (t < 20) begin
					f = (b & c) | (~b & d);
					k = RK0;
				end else if (t < 40) begin
					f = b ^ c ^ d;
					k = RK1;
				end else if (t < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = RK2;
				end else begin
					f = b ^ c ^ d;
					k = RK3;
				end
				sum = rotl(a, 5) + f + e + k + wt;
				e = d;
				d = c;
				c = rotl(b, 30);
				b = a;
				a = sum;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void absorb_byte(bit [7:0] value);
			if (fill[1:0] == 2'd0)
				block[fill[5:2]] = {value, 24'h0};
			else
				block[fill[5:2]][(3 - fill[1:0]) * 8 +: 8] = value;
			fill++;
			if (fill == 6'd0)
				compress_block();
		endfunction

		function void take_item(bit [7:0] value, bit carries_byte, bit ends);
			bit [63:0] bit_len;
			digest_word_t entry;
			int i;
			if (carries_byte) begin
				absorb_byte(value);
				msg_bytes++;
			end
			if (!ends)
				return;
			bit_len = {msg_bytes, 3'b000};
			absorb_byte(PAD_BYTE);
			while (fill != 6'd56)
				absorb_byte(8'h00);
			for (i = 7; i >= 0; i--)
				absorb_byte(bit_len[i * 8 +: 8]);
			for (i = 0; i < DIGEST_WORDS; i++) begin
				entry = '{chain[i], 3'(i), i == DIGEST_WORDS - 1};
				owed_words = {owed_words, entry};
			end
			restart();
		endfunction

		task report(string msg);
			$display("%0t ns: digest mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_word(logic [31:0] word, logic [2:0] index, logic last);
			digest_word_t exp;
			if (owed_words.size() == 0) begin
				report($sformatf("unexpected word %h index %0d", word, index));
				return;
			end
			exp = owed_words.pop_front();
			if (word !== exp.word)
				report($sformatf("word %h, expected %h (index %0d)", word, exp.word,
					exp.index));
			if (index !== exp.index)
				report($sformatf("word_index %0d, expected %0d", index, exp.index));
			if (last !== exp.last)
				report($sformatf("last_word %b, expected %b (index %0d)", last,
					exp.last, exp.index));
		endtask

		function int pending();
			return owed_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic        full;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        empty;

	digest_tracker tracker = new;
	bit  steady = 1'b0;
	bit  calm_msg = 1'b0;
	int  quiet_cycles = 0;
	int  pop_hold = 0;
	int  pop_calm = 0;
	int  byte_items = 0;
	int  messages = 0;

	sha1_hash_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.end_of_message(end_of_message),
		.push(push),
		.full(full),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word),
		.empty(empty),
		.pop(pop)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver stalls in bursts, with occasional long calm stretches.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold != 0) begin
			pop <= 1'b0;
			pop_hold <= pop_hold - 1;
		end else begin
			pop <= 1'b1;
			if (pop_calm != 0)
				pop_calm <= pop_calm - 1;
			else if (!steady && $urandom_range(0, 39) == 0)
				pop_calm <= 100;
			else if (!steady && $urandom_range(0, 6) == 0)
				pop_hold <= $urandom_range(1, 14);
		end
	end

	// A word popped at the same edge as an end item belongs to an earlier
	// message, so it is checked before the item is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				tracker.check_word(digest_word, word_index, last_word);
			if (push && !full)
				tracker.take_item(data_byte, has_byte, end_of_message);
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("sha1_hash_engine_tb: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_item(input logic [7:0] value, input logic carries_byte,
		input logic ends);
		push <= 1'b1;
		data_byte <= value;
		has_byte <= carries_byte;
		end_of_message <= ends;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
	endtask

	task automatic idle(input int cycles);
		push <= 1'b0;
		data_byte <= 8'($urandom_range(0, 255));
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_gap();
		if (!steady && !calm_msg && $urandom_range(0, 5) == 0)
			idle($urandom_range(1, 14));
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// The final byte either rides on the end item or is followed by an end
	// item that carries no byte; ignored items are scattered through.
	task automatic send_message(input int len);
		bit end_alone;
		int i;
		end_alone = (len == 0) || ($urandom_range(0, 1) == 1);
		for (i = 0; i < len; i++) begin
			maybe_gap();
			if ($urandom_range(0, 7) == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				byte_items++;
			end
			send_item(8'($urandom_range(0, 255)), 1'b1, !end_alone && i == len - 1);
		end
		if (end_alone) begin
			maybe_gap();
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
		byte_items += len + (end_alone ? 1 : 0);
		messages++;
	endtask

	initial begin
		int len;
		tracker.restart();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, with a stray byte value on the end item.
		send_item(8'hFF, 1'b0, 1'b1);
		// "abc", last byte on the end item.
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		// Single byte, an ignored item, then an end item with no byte.
		send_item(8'hFF, 1'b1, 1'b0);
		idle(3);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(PAD_BYTE, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b1);
		// Hold the sender back until every digest owed has arrived.
		drain();

		while (byte_items < TARGET_ITEMS || messages < MIN_MESSAGES) begin
			if (byte_items >= TARGET_ITEMS * 4 / 5)
				steady = 1'b1;
			calm_msg = ($urandom_range(0, 2) == 0);
			// Lengths around 55, 56 and 64 bytes decide whether padding needs a
			// second block, so they are favoured alongside short messages.
			case ($urandom_range(0, 9))
				0: len = 0;
				1, 2: begin
					case ($urandom_range(0, 7))
						0: len = 55;
						1: len = 56;
						2: len = 57;
						3: len = 63;
						4: len = 64;
						5: len = 65;
						6: len = 119;
						default: len = 120;
					endcase
				end
				default: len = $urandom_range(1, 24);
			endcase
			send_message(len);
			if (!steady && $urandom_range(0, 9) == 0)
				drain();
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("sha1_hash_engine_tb: clean");
		else
			$display("sha1_hash_engine_tb: errors");
		$finish;
	end

endmodule
